### design/graphic_eq_biquad_cascade_unit_assert.svh
// assertion macros for the biquad cascade equalizer
`ifndef GRAPHIC_EQ_BIQUAD_CASCADE_UNIT_ASSERT_SVH
`define GRAPHIC_EQ_BIQUAD_CASCADE_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define GEQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define GEQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/geq_bq_pkg.sv
// shared types and constants for the biquad cascade equalizer
`timescale 1ns / 1ps
package geq_bq_pkg;
    localparam int BANDS          = 10;
    localparam int COEF_FRAC_BITS = 20;
    localparam int ENABLE_BITS    = 10;
    localparam int COEF_W         = 24;
    localparam int HIST_W         = 32;
    localparam int BAND_W         = 4;
    localparam int COEF_DEPTH     = BANDS * 5;
    localparam int HIST_DEPTH     = BANDS * 4;
    localparam int COEF_AW        = $clog2(COEF_DEPTH);
    localparam int HIST_AW        = $clog2(HIST_DEPTH);
    localparam int ACC_W          = 64;

    localparam logic [2:0] COEF_A0 = 3'd0;
    localparam logic [2:0] COEF_A1 = 3'd1;
    localparam logic [2:0] COEF_A2 = 3'd2;
    localparam logic [2:0] COEF_B1 = 3'd3;
    localparam logic [2:0] COEF_B2 = 3'd4;

    localparam logic FUNC_AUDIO = 1'b0;
    localparam logic FUNC_COEF  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_BAND, ST_RD, ST_MAC, ST_MACW, ST_SCALE, ST_WB, ST_OUT
    } geq_state_t;

    // one product request from the sequencer to the mac
    typedef struct packed {
        logic clear;
        logic en;
        logic sub;
    } geq_mac_ctl_t;
endpackage

### design/geq_bq_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module geq_bq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end
    assign rdata = rdata_reg;
endmodule

### design/geq_bq_mac.sv
// multiply-accumulate unit, product registered before accumulation
`timescale 1ns / 1ps
module geq_bq_mac
    import geq_bq_pkg::*;
(
    input  logic                     aclk,
    input  geq_mac_ctl_t             ctl,
    input  logic signed [COEF_W-1:0] coef,
    input  logic signed [HIST_W-1:0] data,
    output logic signed [ACC_W-1:0]  acc
);
    logic signed [COEF_W+HIST_W-1:0] prod_reg;
    logic                            pen_reg;
    logic                            psub_reg;
    logic signed [ACC_W-1:0]         acc_reg;
    logic signed [ACC_W-1:0]         pext;

    assign pext = ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        prod_reg <= coef * data;
        pen_reg  <= ctl.en;
        psub_reg <= ctl.sub;
        if (ctl.clear) begin
            acc_reg <= '0;
        end else if (pen_reg) begin
            acc_reg <= psub_reg ? acc_reg - pext : acc_reg + pext;
        end
    end
    assign acc = acc_reg;
endmodule

### design/graphic_eq_biquad_cascade_unit.sv
// top level of the biquad cascade equalizer
`timescale 1ns / 1ps
// Ten-band direct-form-I biquad cascade. Coefficients and history live in two
// single-port rams sharing one multiply-accumulator; each enabled band runs a
// band check, five history-read steps, five coefficient reads each followed by
// a product, a wait for the accumulator to settle and four history writes, and
// a disabled band only the band check. An audio transaction stalls the input
// through all band passes and the output step, longer while the previous result
// still waits for m_tready; a coefficient transaction is written in idle. After
// reset a clearing pass zeroes both rams before the first transaction is taken.
`include "graphic_eq_biquad_cascade_unit_assert.svh"
module graphic_eq_biquad_cascade_unit
    import geq_bq_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [ENABLE_BITS-1:0] cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // sample_in[15:0], band_sel[19:16], coef_sel[22:20], coef_value[46:23], pad
    input  logic [47:0]            s_tdata,
    input  logic                   s_tuser,   // func
    input  logic                   s_tlast,   // block_end
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // sample_out[15:0], clipped[16], pad
    output logic [23:0]            m_tdata,
    output logic                   m_tlast    // block_end_out
);
    geq_state_t state_reg, state_next;
    logic [ENABLE_BITS-1:0] enable_reg;
    logic [BAND_W-1:0] band_reg, band_next;
    logic [2:0] step_reg, step_next;
    logic [COEF_AW-1:0] clr_reg, clr_next;
    logic signed [HIST_W-1:0] v_reg, v_next;
    logic signed [HIST_W-1:0] h_reg [4];
    logic [1:0] hcap_reg;
    logic last_reg;
    logic ovalid_reg, ovalid_next;
    logic [15:0] oq_reg, oq_next;
    logic oclip_reg, oclip_next, olast_reg;

    logic c_we, h_we;
    logic [COEF_AW-1:0] c_addr;
    logic [HIST_AW-1:0] h_addr;
    logic [COEF_W-1:0] c_wdata, c_rdata;
    logic [HIST_W-1:0] h_wdata, h_rdata;
    geq_mac_ctl_t mctl;
    logic signed [HIST_W-1:0] mdata;
    logic signed [ACC_W-1:0] acc;
    logic hcap_en;

    logic [BAND_W-1:0] s_band;
    logic [2:0] s_sel;
    logic signed [ACC_W-1:0] q64;
    logic signed [HIST_W-1:0] ysat;
    logic [COEF_AW-1:0] cbase;
    logic [HIST_AW-1:0] hbase;

    geq_bq_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef (
        .aclk(aclk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata));
    geq_bq_ram #(.WIDTH(HIST_W), .DEPTH(HIST_DEPTH)) u_hist (
        .aclk(aclk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));
    geq_bq_mac u_mac (
        .aclk(aclk), .ctl(mctl), .coef(c_rdata), .data(mdata), .acc(acc));

    assign s_band = s_tdata[19:16];
    assign s_sel  = s_tdata[22:20];
    assign cbase  = COEF_AW'(band_reg * 5);
    assign hbase  = HIST_AW'({band_reg, 2'b00});
    assign q64    = acc >>> COEF_FRAC_BITS;
    assign ysat   = (q64 > ACC_W'(64'sh7FFFFFFF)) ? 32'sh7FFFFFFF :
                    (q64 < -ACC_W'(64'sh80000000)) ? 32'sh80000000 : HIST_W'(q64);
    // step 0 multiplies x, steps 1..4 multiply history words
    assign mdata  = (step_reg == 3'd0) ? v_reg : h_reg[2'(step_reg - 3'd1)];
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {7'd0, oclip_reg, oq_reg};
    assign m_tlast  = olast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            enable_reg <= '0;
            ovalid_reg <= 1'b0;
            clr_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            clr_reg    <= clr_next;
            if (cfg_valid && cfg_ready) begin
                enable_reg <= cfg_data;
            end
        end
        band_reg <= band_next;
        step_reg <= step_next;
        v_reg    <= v_next;
        oq_reg   <= oq_next;
        oclip_reg <= oclip_next;
        hcap_reg <= h_addr[1:0];
        if (hcap_en) begin
            h_reg[hcap_reg] <= h_rdata;
        end
        if (s_tvalid && s_tready) begin
            last_reg <= s_tlast;
        end
        if (state_reg == ST_OUT && (!ovalid_reg || m_tready)) begin
            olast_reg <= last_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        band_next = band_reg;
        step_next = step_reg;
        clr_next = clr_reg;
        v_next = v_reg;
        ovalid_next = ovalid_reg && !m_tready;
        oq_next = oq_reg;
        oclip_next = oclip_reg;
        s_tready = 1'b0;
        c_we = 1'b0;
        h_we = 1'b0;
        c_addr = cbase;
        h_addr = hbase;
        c_wdata = s_tdata[46:23];
        h_wdata = v_reg;
        hcap_en = 1'b0;
        mctl = '{clear: 1'b0, en: 1'b0, sub: 1'b0};
        unique case (state_reg)
            ST_CLEAR: begin
                c_we = 1'b1;
                c_addr = clr_reg;
                c_wdata = '0;
                h_we = (clr_reg < COEF_AW'(HIST_DEPTH));
                h_addr = HIST_AW'(clr_reg);
                h_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == COEF_AW'(COEF_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == FUNC_COEF) begin
                        c_addr = COEF_AW'(s_band * 5 + s_sel);
                        c_we = (s_band < BAND_W'(BANDS)) && (s_sel <= COEF_B2);
                    end else begin
                        v_next = HIST_W'(signed'(s_tdata[15:0])) <<< 8;
                        band_next = '0;
                        state_next = ST_BAND;
                    end
                end
            end
            ST_BAND: begin
                step_next = '0;
                if (band_reg >= BAND_W'(BANDS)) begin
                    state_next = ST_OUT;
                end else if (band_reg < BAND_W'(ENABLE_BITS) &&
                             enable_reg[band_reg]) begin
                    state_next = ST_RD;
                end else begin
                    band_next = band_reg + 1'b1;
                end
            end
            ST_RD: begin
                // fetch the four history words, captured in the next cycle
                h_addr = hbase + HIST_AW'(step_reg[1:0]);
                hcap_en = (step_reg != 3'd0);
                mctl.clear = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd4) begin
                    step_next = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                // coefficient read issued in the cycle before the product
                c_addr = cbase + COEF_AW'(step_reg);
                state_next = ST_MACW;
            end
            ST_MACW: begin
                mctl.en = 1'b1;
                mctl.sub = (step_reg >= 3'd3);
                if (step_reg == 3'd4) begin
                    step_next = '0;
                    state_next = ST_SCALE;
                end else begin
                    step_next = step_reg + 1'b1;
                    state_next = ST_MAC;
                end
            end
            ST_SCALE: begin
                // wait for the last product to land in the accumulator
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd1) begin
                    step_next = '0;
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                h_we = 1'b1;
                h_addr = hbase + HIST_AW'(step_reg[1:0]);
                case (step_reg[1:0])
                    2'd0: h_wdata = v_reg;
                    2'd1: h_wdata = h_reg[0];
                    2'd2: h_wdata = ysat;
                    default: h_wdata = h_reg[2];
                endcase
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd3) begin
                    v_next = ysat;
                    band_next = band_reg + 1'b1;
                    state_next = ST_BAND;
                end
            end
            ST_OUT: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    if (v_reg > 32'sd8388352) begin
                        oq_next = 16'h7FFF;
                        oclip_next = 1'b1;
                    end else if (v_reg < -32'sd8388608) begin
                        oq_next = 16'h8000;
                        oclip_next = 1'b1;
                    end else begin
                        // truncate toward zero
                        oq_next = 16'((v_reg + (v_reg[31] ? 32'sd255 : 32'sd0)) >>> 8);
                        oclip_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `GEQ_ASSERT_IMP(a_cfg_idle, aclk, aresetn, cfg_ready, state_reg == ST_IDLE,
        "config accepted outside idle")
    `GEQ_ASSERT_IMP(a_in_idle, aclk, aresetn, s_tready, state_reg == ST_IDLE,
        "input taken while busy")
    `GEQ_ASSERT_NEXT(a_out_from_out, aclk, aresetn, !m_tvalid && state_reg != ST_OUT,
        !m_tvalid, "result appeared without output step")
endmodule

### dv/graphic_eq_biquad_cascade_unit_tb.sv
// self-checking testbench for the biquad cascade equalizer
`timescale 1ns / 1ps
class eq_scoreboard;
    localparam int ENABLE_W_C = 10;

    logic [ENABLE_W_C-1:0] enables;
    logic signed [23:0]    coefs   [50];
    logic signed [31:0]    history [40];
    logic [17:0]           pending [$];
    int                    errors;
    int                    checked;
    int                    clip_hits;

    function void clear_state();
        enables = '0;
        foreach (coefs[i]) coefs[i] = '0;
        foreach (history[i]) history[i] = '0;
        pending.delete();
        errors = 0;
        checked = 0;
        clip_hits = 0;
    endfunction

    function logic signed [31:0] filter_band(int b, logic signed [31:0] x);
        logic signed [63:0] acc;
        logic signed [63:0] q;
        logic signed [31:0] y;
        acc = 64'(coefs[b*5]) * 64'(x) + 64'(coefs[b*5+1]) * 64'(history[b*4])
            + 64'(coefs[b*5+2]) * 64'(history[b*4+1])
            - 64'(coefs[b*5+3]) * 64'(history[b*4+2])
            - 64'(coefs[b*5+4]) * 64'(history[b*4+3]);
        q = acc >>> 20;
        if (q > 64'sh7FFFFFFF) y = 32'sh7FFFFFFF;
        else if (q < -64'sh80000000) y = 32'sh80000000;
        else y = q[31:0];
        history[b*4+1] = history[b*4];
        history[b*4]   = x;
        history[b*4+3] = history[b*4+2];
        history[b*4+2] = y;
        return y;
    endfunction

    // note one accepted input transaction
    function void note_input(logic func, logic [47:0] data, logic last);
        logic signed [31:0] v;
        logic signed [31:0] q;
        logic               clip;
        if (func == geq_bq_pkg::FUNC_COEF) begin
            if (data[19:16] < 10 && data[22:20] <= geq_bq_pkg::COEF_B2)
                coefs[data[19:16]*5 + data[22:20]] = data[46:23];
            return;
        end
        v = 32'(signed'(data[15:0])) * 256;
        for (int b = 0; b < 10; b++)
            if (enables[b]) v = filter_band(b, v);
        clip = 1'b0;
        if (v > 32767 * 256) begin
            q = 32767;
            clip = 1'b1;
        end else if (v < -32768 * 256) begin
            q = -32768;
            clip = 1'b1;
        end else begin
            q = v / 256;
        end
        pending.push_back({last, clip, q[15:0]});
    endfunction

    function void check_result(logic [23:0] data, logic last);
        logic [17:0] exp_r;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result data=%h last=%b", $time, data, last);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        checked++;
        if (exp_r[16]) clip_hits++;
        if (data[15:0] !== exp_r[15:0]) begin
            $display("%0t: sample_out expected %h actual %h", $time, exp_r[15:0], data[15:0]);
            errors++;
        end
        if (data[16] !== exp_r[16]) begin
            $display("%0t: clipped expected %b actual %b", $time, exp_r[16], data[16]);
            errors++;
        end
        if (last !== exp_r[17]) begin
            $display("%0t: block_end_out expected %b actual %b", $time, exp_r[17], last);
            errors++;
        end
    endfunction
endclass

module graphic_eq_biquad_cascade_unit_tb;
    import geq_bq_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [ENABLE_BITS-1:0] cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [47:0]            s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [23:0]            m_tdata;
    logic                   m_tlast;

    eq_scoreboard eq_sb;
    longint       cycle_count = 0;
    bit           hold_off = 1'b0;
    bit           stall_enable = 1'b1;
    int           audio_sent = 0;
    int           coef_sent = 0;

    always #1 aclk = ~aclk;

    graphic_eq_biquad_cascade_unit dut (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) eq_sb.check_result(m_tdata, m_tlast);
        if (hold_off) m_tready <= 1'b0;
        else if (!stall_enable) m_tready <= 1'b1;
        else if ($urandom_range(0, 99) < 3) m_tready <= 1'b0;
        else if (!m_tready && $urandom_range(0, 3) != 0) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 9) < 7);
    end

    // a zero gap keeps tvalid high for the next transaction
    task automatic sender_gap();
        int n;
        if (!stall_enable) n = 0;
        else begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
            if ($urandom_range(0, 1) == 0) n = 0;
        end
        if (n != 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_item(logic func, logic [47:0] data, logic last);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        eq_sb.note_input(func, data, last);
        if (func == FUNC_COEF) coef_sent++;
        else audio_sent++;
        sender_gap();
    endtask

    task automatic send_audio(logic signed [15:0] s, logic last);
        logic [47:0] d;
        d = 48'({$urandom, $urandom});
        d[47] = 1'b0;
        d[15:0] = s;
        send_item(FUNC_AUDIO, d, last);
    endtask

    task automatic send_coef(int band, logic [2:0] sel, logic signed [23:0] val);
        logic [47:0] d;
        d = 48'({$urandom, $urandom});
        d[47] = 1'b0;
        d[19:16] = band[3:0];
        d[22:20] = sel;
        d[46:23] = val;
        send_item(FUNC_COEF, d, 1'($urandom_range(0, 1)));
    endtask

    task automatic write_enable(logic [ENABLE_BITS-1:0] v);
        s_tvalid <= 1'b0;
        while (eq_sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        eq_sb.enables = v;
        cfg_valid <= 1'b0;
    endtask

    // coefficient set: a0 of modest gain, small feedback, sometimes wild
    task automatic load_band(int b, bit wild);
        logic signed [23:0] c;
        for (int k = 0; k <= 4; k++) begin
            if (wild) c = 24'($urandom);
            else if (k == 0) c = 24'(int'($urandom_range(0, 1572864)) - 262144);
            else c = 24'(int'($urandom_range(0, 524288)) - 262144);
            send_coef(b, k[2:0], c);
        end
    endtask

    task automatic random_samples(int n);
        logic signed [15:0] s;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: s = 16'sh7FFF;
                1: s = 16'sh8000;
                default: s = 16'($urandom);
            endcase
            if ($urandom_range(0, 19) == 0)
                send_coef($urandom_range(0, 15), 3'($urandom_range(0, 7)), 24'($urandom));
            else
                send_audio(s, $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        eq_sb = new();
        eq_sb.clear_state();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: bypass path, zero coefficients, ignored writes, extremes
        stall_enable = 1'b0;
        send_audio(16'sh7FFF, 1'b0);
        send_audio(16'sh8000, 1'b1);
        send_audio(16'sh0000, 1'b0);
        send_audio(16'shFFFF, 1'b0);
        write_enable(10'h001);
        send_audio(16'sh1234, 1'b1);
        send_coef(10, COEF_A0, 24'sh100000);
        send_coef(15, COEF_A0, 24'sh100000);
        send_coef(0, 3'd5, 24'sh100000);
        send_coef(0, 3'd7, 24'sh7FFFFF);
        send_audio(16'sh4000, 1'b0);
        send_coef(0, COEF_A0, 24'sh7FFFFF);
        send_coef(0, COEF_A1, 24'sh800000);
        send_coef(0, COEF_A2, 24'sh7FFFFF);
        send_coef(0, COEF_B1, 24'sh800000);
        send_coef(0, COEF_B2, 24'sh000001);
        send_audio(16'sh7FFF, 1'b0);
        send_audio(16'sh8000, 1'b1);
        send_audio(16'sh7FFF, 1'b0);
        send_audio(16'sh0001, 1'b0);
        stall_enable = 1'b1;

        // random phases over several enable settings
        for (int b = 0; b < 10; b++) load_band(b, 1'b0);
        write_enable(10'h3FF);
        random_samples(150);
        write_enable(10'h000);
        random_samples(100);

        // receiver holds off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_samples(40);
        join

        for (int b = 0; b < 10; b++) load_band(b, b % 3 == 0);
        write_enable(10'(int'($urandom_range(1, 1022))));
        random_samples(200);
        write_enable(10'h200);
        random_samples(100);
        for (int b = 0; b < 10; b++) load_band(b, 1'b0);
        write_enable(10'(int'($urandom_range(0, 1023))));
        random_samples(200);
        write_enable(10'h3FF);
        random_samples(60);

        s_tvalid <= 1'b0;
        while (eq_sb.pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        $display("run: %0d audio and %0d coefficient transactions, %0d results checked",
                 audio_sent, coef_sent, eq_sb.checked);
        $display("run: %0d clipped results seen, several band enable settings", eq_sb.clip_hits);
        if (eq_sb.errors == 0 && eq_sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
